/* hw/rtl/pq_table_distance_sum_core_defines.svh */
// assertion macros for the pq table distance sum block
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef PQ_TABLE_DISTANCE_SUM_CORE_DEFINES_SVH
`define PQ_TABLE_DISTANCE_SUM_CORE_DEFINES_SVH

// same-cycle implication
`define PTDS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTDS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/ptds_pkg.sv */
// shared types and constants of the pq table distance sum block
// no dependencies
package ptds_pkg;

  localparam int CHUNK_W = 6;
  localparam int CODE_W  = 8;
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 38;
  localparam int IDX_W   = 16;
  localparam int NUM_W   = 7;
  localparam int CNT_W   = 9;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // result queue depth: covers one result in the pipe plus two queued
  localparam int OFIFO_DEPTH = 3;
  localparam int OFIFO_PW    = 2;

  // register word index within paddr[2]
  localparam logic [0:0] REG_NUM_CHUNKS = 1'b0;

  typedef enum logic {
    OP_TABLE_WRITE = 1'b0,
    OP_POINT_CODE  = 1'b1
  } opcode_e;

  // code request on its way from the table read to the accumulator
  typedef struct packed {
    logic             fin;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } s1_t;

  typedef struct packed {
    logic [SUM_W-1:0] distance;
    logic [IDX_W-1:0] point_index;
  } out_t;

endpackage

/* hw/rtl/ptds_if.sv */
// request and result channel interfaces of the pq table distance sum block
// depends on ptds_pkg
interface ptds_in_if;
  import ptds_pkg::*;
  logic                valid;
  logic                ready;
  opcode_e             opcode;
  logic [CHUNK_W-1:0]  table_chunk;
  logic [CODE_W-1:0]   table_code;
  logic [VAL_W-1:0]    table_value;
  logic [CODE_W-1:0]   point_code;
  logic                batch_end;

  modport source (output valid, opcode, table_chunk, table_code, table_value,
                  point_code, batch_end, input ready);
  modport sink   (input valid, opcode, table_chunk, table_code, table_value,
                  point_code, batch_end, output ready);
endinterface

interface ptds_out_if;
  import ptds_pkg::*;
  logic              valid;
  logic              ready;
  logic [SUM_W-1:0]  distance;
  logic [IDX_W-1:0]  point_index;

  modport source (output valid, distance, point_index, input ready);
  modport sink   (input valid, distance, point_index, output ready);
endinterface

/* hw/rtl/ptds_table.sv */
// distance table memory: one write port and one read port, registered read
// depends on ptds_pkg
module ptds_table #(
  parameter int AW = 14
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [ptds_pkg::VAL_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [ptds_pkg::VAL_W-1:0] rd_data_o
);
  import ptds_pkg::*;

  logic [VAL_W-1:0] mem [2**AW];
  logic [VAL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/ptds_ctrl.sv */
// request sequencer: chunk position, point counter, table addressing
// depends on ptds_pkg
module ptds_ctrl #(
  parameter int MAX_CHUNKS    = 64,
  parameter int CODEBOOK_SIZE = 256,
  parameter int AW            = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  ptds_pkg::opcode_e            opcode_i,
  input  logic [ptds_pkg::CHUNK_W-1:0] table_chunk_i,
  input  logic [ptds_pkg::CODE_W-1:0]  table_code_i,
  input  logic [ptds_pkg::CODE_W-1:0]  point_code_i,
  input  logic                         batch_end_i,
  input  logic [ptds_pkg::CNT_W-1:0]   n_eff_i,
  output logic                         wr_en_o,
  output logic [AW-1:0]                wr_addr_o,
  output logic                         rd_en_o,
  output logic [AW-1:0]                rd_addr_o,
  output logic                         s1_valid_o,
  output ptds_pkg::s1_t                s1_o
);
  import ptds_pkg::*;

  localparam int ChW = (MAX_CHUNKS <= 2) ? 1 :
                       ((MAX_CHUNKS > 64) ? CHUNK_W : $clog2(MAX_CHUNKS));
  localparam int CbW = $clog2(CODEBOOK_SIZE);
  localparam logic [CNT_W-1:0] MaxN = CNT_W'(MAX_CHUNKS);
  localparam logic [CNT_W-1:0] CbN  = CNT_W'(CODEBOOK_SIZE);

  logic [CHUNK_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0]   pc_q, pc_d;
  logic               s1_valid_q;
  s1_t                s1_q;
  logic [CNT_W-1:0]   pos_inc;
  logic               is_code, code_acc, finish, hit;

  assign is_code  = (opcode_i == OP_POINT_CODE);
  assign code_acc = accept_i && is_code;
  assign pos_inc  = CNT_W'(pos_q) + CNT_W'(1);
  assign finish   = (pos_inc >= n_eff_i);
  assign hit      = (CNT_W'(point_code_i) < CbN) && (CNT_W'(pos_q) < MaxN);

  assign wr_en_o   = accept_i && !is_code && (CNT_W'(table_chunk_i) < MaxN)
                     && (CNT_W'(table_code_i) < CbN);
  assign wr_addr_o = {table_chunk_i[ChW-1:0], table_code_i[CbW-1:0]};
  assign rd_en_o   = code_acc;
  assign rd_addr_o = {pos_q[ChW-1:0], point_code_i[CbW-1:0]};

  always_comb begin
    pos_d = pos_q;
    pc_d  = pc_q;
    if (code_acc) begin
      pos_d = finish ? '0 : pos_inc[CHUNK_W-1:0];
      if (finish) begin
        pc_d = pc_q + IDX_W'(1);
      end
      if (batch_end_i) begin
        pc_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      pc_q       <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      pc_q       <= pc_d;
      s1_valid_q <= code_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (code_acc) begin
      s1_q.fin <= finish;
      s1_q.hit <= hit;
      s1_q.idx <= pc_q;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_o       = s1_q;

endmodule

/* hw/rtl/ptds_acc.sv */
// running sum: adds the table read data and releases finished points
// depends on ptds_pkg
module ptds_acc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s1_valid_i,
  input  ptds_pkg::s1_t              s1_i,
  input  logic [ptds_pkg::VAL_W-1:0] rd_data_i,
  output logic                       push_o,
  output ptds_pkg::out_t             push_data_o
);
  import ptds_pkg::*;

  logic [SUM_W-1:0] sum_q, sum_d, sum_new;

  // out-of-range codes still count as a chunk but add nothing
  assign sum_new = sum_q + (s1_i.hit ? SUM_W'(rd_data_i) : '0);

  always_comb begin
    sum_d = sum_q;
    if (s1_valid_i) begin
      sum_d = s1_i.fin ? '0 : sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign push_o                  = s1_valid_i && s1_i.fin;
  assign push_data_o.distance    = sum_new;
  assign push_data_o.point_index = s1_i.idx;

endmodule

/* hw/rtl/ptds_ofifo.sv */
// three-entry result queue in front of the output channel
// depends on ptds_pkg
module ptds_ofifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  ptds_pkg::out_t                push_data_i,
  input  logic                          pop_i,
  output ptds_pkg::out_t                head_o,
  output logic [ptds_pkg::OFIFO_PW-1:0] cnt_o
);
  import ptds_pkg::*;

  localparam logic [OFIFO_PW-1:0] LastPtr = OFIFO_PW'(OFIFO_DEPTH - 1);

  out_t                entries_q [OFIFO_DEPTH];
  logic [OFIFO_PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + OFIFO_PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + OFIFO_PW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + OFIFO_PW'(1);
      2'b01:   cnt_d = cnt_q - OFIFO_PW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o = entries_q[rd_ptr_q];
  assign cnt_o  = cnt_q;

endmodule

/* hw/rtl/pq_table_distance_sum_core.sv */
// pq table distance sum: top level, apb register and channel glue
// depends on ptds_pkg, ptds_if, ptds_table, ptds_ctrl, ptds_acc, ptds_ofifo
//
// usage
//   in_ch carries requests. opcode table write stores table_value at (table_chunk,
//   table_code) of the per-query distance table; opcode point code adds the table
//   entry of the current chunk for point_code to the running sum. after num_chunks
//   code requests one result leaves on out_ch: the summed distance and the point
//   index. batch_end restarts the index. num_chunks sits at apb byte address 0; the
//   user must see it written only while idle, as the block does not enforce it.
// timing
//   one request per cycle while in_ch.ready is high. a code request reads the
//   table memory at its accept edge and the sum is updated at the next edge,
//   when a finishing point is queued: its result passes the request and read
//   registers, then the result queue. each request uses either the write or the
//   read port of the memory, so a read never meets a write of the same cycle.
// reset and stall
//   reset clears counters, the sum and the result queue and sets num_chunks
//   to 1; the table is not cleared. a stalled receiver fills the three-entry
//   result queue; in_ch.ready drops once queue and pipe hold three results.
module pq_table_distance_sum_core #(
  parameter int MAX_CHUNKS    = 64,
  parameter int CODEBOOK_SIZE = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ptds_in_if.sink                       in_ch,
  ptds_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptds_pkg::PADDR_W-1:0]  paddr,
  input  logic [ptds_pkg::PDATA_W-1:0]  pwdata,
  output logic [ptds_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import ptds_pkg::*;

  // table address: chunk bits above code bits
  localparam int ChW = (MAX_CHUNKS <= 2) ? 1 :
                       ((MAX_CHUNKS > 64) ? CHUNK_W : $clog2(MAX_CHUNKS));
  localparam int CbW = $clog2(CODEBOOK_SIZE);
  localparam int AW  = ChW + CbW;
  localparam logic [CNT_W-1:0] MaxN = CNT_W'(MAX_CHUNKS);

  logic [NUM_W-1:0]    num_q;
  logic [CNT_W-1:0]    n_eff;
  logic                cfg_wr;
  logic                accept;
  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [VAL_W-1:0]    rd_data;
  logic                s1_valid;
  s1_t                 s1;
  logic                push, pop;
  out_t                push_data, head;
  logic [OFIFO_PW-1:0] fifo_cnt;
  logic [OFIFO_PW:0]   pending;

  // apb: zero wait states, writes land on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= NUM_W'(1);
    end else if (cfg_wr && (paddr[2] == REG_NUM_CHUNKS)) begin
      num_q <= pwdata[NUM_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NUM_CHUNKS: prdata = PDATA_W'(num_q);
      default:        prdata = '0;
    endcase
  end

  // zero acts as one chunk, anything past the table depth clamps to it
  always_comb begin
    if (num_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (CNT_W'(num_q) > MaxN) begin
      n_eff = MaxN;
    end else begin
      n_eff = CNT_W'(num_q);
    end
  end

  // results still owed: queued ones plus a finishing point in the sum stage
  assign pending     = OFIFO_PW'(0) + (OFIFO_PW + 1)'(fifo_cnt)
                       + (OFIFO_PW + 1)'(s1_valid && s1.fin);
  assign in_ch.ready = (pending < (OFIFO_PW + 1)'(OFIFO_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  ptds_ctrl #(
    .MAX_CHUNKS    (MAX_CHUNKS),
    .CODEBOOK_SIZE (CODEBOOK_SIZE),
    .AW            (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .opcode_i      (in_ch.opcode),
    .table_chunk_i (in_ch.table_chunk),
    .table_code_i  (in_ch.table_code),
    .point_code_i  (in_ch.point_code),
    .batch_end_i   (in_ch.batch_end),
    .n_eff_i       (n_eff),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .s1_valid_o    (s1_valid),
    .s1_o          (s1)
  );

  ptds_table #(
    .AW (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_ch.table_value),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ptds_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_i        (s1),
    .rd_data_i   (rd_data),
    .push_o      (push),
    .push_data_o (push_data)
  );

  assign pop = out_ch.valid && out_ch.ready;

  ptds_ofifo u_ofifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .cnt_o       (fifo_cnt)
  );

  assign out_ch.valid       = (fifo_cnt != '0);
  assign out_ch.distance    = head.distance;
  assign out_ch.point_index = head.point_index;

endmodule

/* hw/rtl/ptds_checker.sv */
// port-level checks of the pq table distance sum block, bound to the top level
// depends on ptds_pkg and pq_table_distance_sum_core_defines.svh
`include "pq_table_distance_sum_core_defines.svh"

module ptds_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input ptds_pkg::opcode_e            in_opcode_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [ptds_pkg::SUM_W-1:0]   out_distance_i,
  input logic [ptds_pkg::IDX_W-1:0]   out_point_index_i
);
  import ptds_pkg::*;

  logic                     out_stall;
  logic [SUM_W+IDX_W-1:0]   out_data;
  logic                     in_code_acc;

  assign out_stall   = out_valid_i && !out_ready_i;
  assign out_data    = {out_distance_i, out_point_index_i};
  // a taken code request can surface as a result via the request register and the result queue
  assign in_code_acc = in_valid_i && in_ready_i && (in_opcode_i == OP_POINT_CODE);

  `PTDS_ASSERT_NXT(a_out_valid_holds, out_stall, out_valid_i, "result dropped while stalled")
  `PTDS_ASSERT_NXT(a_out_data_holds, out_stall, $stable(out_data), "result changed while stalled")
  `PTDS_ASSERT_IMP(a_backpressure_cause, !in_ready_i, out_valid_i, "requests held, no result")
  `PTDS_ASSERT_IMP(a_result_from_code, $rose(out_valid_i), $past(in_code_acc, 2), "stray result")

endmodule

bind pq_table_distance_sum_core ptds_checker u_ptds_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_ch.valid),
  .in_ready_i        (in_ch.ready),
  .in_opcode_i       (in_ch.opcode),
  .out_valid_i       (out_ch.valid),
  .out_ready_i       (out_ch.ready),
  .out_distance_i    (out_ch.distance),
  .out_point_index_i (out_ch.point_index)
);
